// ----- rtl/mmss_countdown_timer_unit_defines.svh -----
// Assertion macros for the MM:SS countdown timer.
// Used by the top level only; expects clk and arst_n in scope.
`ifndef MMSS_COUNTDOWN_TIMER_UNIT_DEFINES_SVH
`define MMSS_COUNTDOWN_TIMER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define MCT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define MCT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/mct_pkg.sv -----
// Shared types and constants for the MM:SS countdown timer.
// No dependencies; used by every module of the block.
package mct_pkg;

	localparam int unsigned TICKS_PER_SECOND_DEF = 1000;
	localparam int unsigned MS_W = 32;
	localparam int unsigned REM_W = 13;

	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;
	localparam logic [3:0] TEXT_LEN = 4'd5;
	localparam logic [3:0] SEC_TENS_LIMIT = 4'd6;
	localparam logic [REM_W-1:0] MAX_REMAINING = 13'd5999;

	typedef enum logic [0:0] {
		OP_LOAD = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef struct packed {
		op_t opcode;
		logic [MS_W-1:0] now_ms;
		logic [3:0] text_length;
		logic [7:0] char_0;
		logic [7:0] char_1;
		logic [7:0] char_2;
		logic [7:0] char_3;
		logic [7:0] char_4;
	} in_item_t;

	typedef struct packed {
		logic [REM_W-1:0] remaining_seconds;
		logic running;
		logic load_accepted;
	} out_item_t;

	// Control carried down the pipeline with each item.
	typedef struct packed {
		logic valid;
		op_t opcode;
		logic load_ok;
		logic [REM_W-1:0] load_val;
		logic [MS_W-1:0] delta_ms;
	} pipe_ctl_t;

endpackage

// ----- rtl/mct_front.sv -----
// Input register, text decode and timestamp delta stage.
// Depends on mct_pkg.
module mct_front (
	input logic clk,
	input logic arst_n,
	input logic adv,
	input logic in_valid,
	input mct_pkg::in_item_t in_item,
	output mct_pkg::pipe_ctl_t ctl_s2
);

	mct_pkg::in_item_t item_s1;
	logic valid_s1;
	logic [mct_pkg::MS_W-1:0] last_now_q;

	logic [3:0] dig_m10;
	logic [3:0] dig_m1;
	logic [3:0] dig_s10;
	logic [3:0] dig_s1;
	logic digits_ok;
	logic load_ok;
	logic [mct_pkg::REM_W-1:0] load_val;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= mct_pkg::CHAR_ZERO) && (c <= mct_pkg::CHAR_NINE);
	endfunction

	assign dig_m10 = 4'(item_s1.char_0 - mct_pkg::CHAR_ZERO);
	assign dig_m1 = 4'(item_s1.char_1 - mct_pkg::CHAR_ZERO);
	assign dig_s10 = 4'(item_s1.char_3 - mct_pkg::CHAR_ZERO);
	assign dig_s1 = 4'(item_s1.char_4 - mct_pkg::CHAR_ZERO);

	assign digits_ok = is_digit(item_s1.char_0) && is_digit(item_s1.char_1)
		&& is_digit(item_s1.char_3) && is_digit(item_s1.char_4);

	assign load_ok = (item_s1.opcode == mct_pkg::OP_LOAD)
		&& (item_s1.text_length == mct_pkg::TEXT_LEN)
		&& (item_s1.char_2 == mct_pkg::CHAR_COLON)
		&& digits_ok && (dig_s10 < mct_pkg::SEC_TENS_LIMIT);

	assign load_val = 13'(dig_m10) * 13'd600 + 13'(dig_m1) * 13'd60
		+ 13'(dig_s10) * 13'd10 + 13'(dig_s1);

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1 <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_now_q <= '0;
			ctl_s2 <= '0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			ctl_s2.valid <= valid_s1;
			ctl_s2.opcode <= item_s1.opcode;
			ctl_s2.load_ok <= load_ok;
			ctl_s2.load_val <= load_val;
			ctl_s2.delta_ms <= item_s1.now_ms - last_now_q;
			if (valid_s1 && (load_ok || item_s1.opcode == mct_pkg::OP_TICK)) begin
				last_now_q <= item_s1.now_ms;
			end
		end
	end

endmodule

// ----- rtl/mct_div.sv -----
// Constant divider: splits the timestamp delta into whole seconds and a remainder.
// Reciprocal multiply, back multiply and one correction step. Depends on mct_pkg.
module mct_div #(
	parameter int unsigned TICKS_PER_SECOND = mct_pkg::TICKS_PER_SECOND_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic adv,
	input mct_pkg::pipe_ctl_t ctl_s2,
	output mct_pkg::pipe_ctl_t ctl_s5,
	output logic [mct_pkg::MS_W-1:0] q_s5,
	output logic [$clog2(TICKS_PER_SECOND+1)-1:0] r_s5
);

	localparam int unsigned RW = $clog2(TICKS_PER_SECOND + 1);
	localparam int unsigned LOG_T = $clog2(TICKS_PER_SECOND);
	localparam int unsigned SHIFT = 31 + LOG_T;
	localparam logic [63:0] RECIP_FULL = (64'd1 << SHIFT) / 64'(TICKS_PER_SECOND);
	localparam logic [31:0] RECIP = RECIP_FULL[31:0];
	localparam logic [mct_pkg::MS_W-1:0] TICKS_MS = mct_pkg::MS_W'(TICKS_PER_SECOND);
	localparam logic [RW:0] TICKS_R = (RW+1)'(TICKS_PER_SECOND);

	mct_pkg::pipe_ctl_t ctl_s3;
	mct_pkg::pipe_ctl_t ctl_s4;
	logic [63:0] prod_s3;
	logic [mct_pkg::MS_W-1:0] q_s4;
	logic [RW:0] r0_s4;

	logic [63:0] prod_sh;
	logic [mct_pkg::MS_W-1:0] q0;
	logic [mct_pkg::MS_W-1:0] r0_full;
	logic [RW:0] r_fix;

	assign prod_sh = prod_s3 >> SHIFT;
	assign q0 = prod_sh[mct_pkg::MS_W-1:0];
	assign r0_full = ctl_s3.delta_ms - mct_pkg::MS_W'(q0 * TICKS_MS);
	assign r_fix = r0_s4 - TICKS_R;

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s3 <= 64'(ctl_s2.delta_ms) * 64'(RECIP);
			q_s4 <= q0;
			r0_s4 <= r0_full[RW:0];
			if (r0_s4 >= TICKS_R) begin
				q_s5 <= q_s4 + 32'd1;
				r_s5 <= r_fix[RW-1:0];
			end else begin
				q_s5 <= q_s4;
				r_s5 <= r0_s4[RW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else if (adv) begin
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
		end
	end

endmodule

// ----- rtl/mct_core.sv -----
// Countdown state update and result register.
// Keeps the remaining seconds and the sub-second residue. Depends on mct_pkg.
module mct_core #(
	parameter int unsigned TICKS_PER_SECOND = mct_pkg::TICKS_PER_SECOND_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic adv,
	input mct_pkg::pipe_ctl_t ctl_s5,
	input logic [mct_pkg::MS_W-1:0] q_s5,
	input logic [$clog2(TICKS_PER_SECOND+1)-1:0] r_s5,
	output logic out_valid,
	output mct_pkg::out_item_t out_item
);

	localparam int unsigned RW = $clog2(TICKS_PER_SECOND + 1);
	localparam logic [RW:0] TICKS_R = (RW+1)'(TICKS_PER_SECOND);

	logic [mct_pkg::REM_W-1:0] remaining_q;
	logic [RW-1:0] residual_q;
	logic started_q;

	logic [mct_pkg::MS_W:0] sum_wide;
	logic wrapped;
	logic [RW:0] frac_sum;
	logic [RW:0] frac_fix;
	logic carry_sec;
	logic [mct_pkg::MS_W-1:0] secs;
	logic [RW-1:0] residual_next;
	logic [mct_pkg::REM_W-1:0] remaining_next;
	logic started_next;
	logic accepted;

	// The item's delta is measured from the last accepted load or tick; the residue
	// adds the part of a second that the reference still lags behind it.
	assign sum_wide = {1'b0, ctl_s5.delta_ms} + (mct_pkg::MS_W+1)'(residual_q);
	assign wrapped = sum_wide[mct_pkg::MS_W];
	assign frac_sum = {1'b0, r_s5} + {1'b0, residual_q};
	assign frac_fix = frac_sum - TICKS_R;
	assign carry_sec = frac_sum >= TICKS_R;

	always_comb begin
		secs = '0;
		residual_next = residual_q;
		remaining_next = remaining_q;
		started_next = started_q;
		accepted = 1'b0;
		unique case (ctl_s5.opcode)
			mct_pkg::OP_LOAD: begin
				if (ctl_s5.load_ok) begin
					remaining_next = ctl_s5.load_val;
					residual_next = '0;
					started_next = 1'b1;
					accepted = 1'b1;
				end
			end
			mct_pkg::OP_TICK: begin
				if (started_q) begin
					if (wrapped) begin
						secs = '0;
						residual_next = sum_wide[RW-1:0];
					end else if (carry_sec) begin
						secs = q_s5 + 32'd1;
						residual_next = frac_fix[RW-1:0];
					end else begin
						secs = q_s5;
						residual_next = frac_sum[RW-1:0];
					end
					if (secs >= mct_pkg::MS_W'(remaining_q)) begin
						remaining_next = '0;
					end else begin
						remaining_next = remaining_q - secs[mct_pkg::REM_W-1:0];
					end
				end
			end
			default: begin
				secs = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv && ctl_s5.valid) begin
			residual_q <= residual_next;
			out_item.remaining_seconds <= remaining_next;
			out_item.running <= started_next;
			out_item.load_accepted <= accepted;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remaining_q <= '0;
			started_q <= 1'b0;
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= ctl_s5.valid;
			if (ctl_s5.valid) begin
				remaining_q <= remaining_next;
				started_q <= started_next;
			end
		end
	end

endmodule

// ----- rtl/mmss_countdown_timer_unit.sv -----
// Top level of the MM:SS countdown timer: front stage, divider and state core.
// Depends on mct_pkg, mct_front, mct_div, mct_core and the assertion macro header.
//
//   channel | payload               | handshake
//   --------+-----------------------+-------------------------------
//   in      | mct_pkg::in_item_t    | in_valid / in_stall (ours)
//   out     | mct_pkg::out_item_t   | out_valid / out_stall (theirs)
//
// One item is taken per cycle unless a stalled result freezes the pipeline.
// Each result passes through the input register, the decode stage, the three divider
// stages and the result register.
// A stalled result freezes the whole pipeline, so in_stall follows out_stall while a
// result waits.
// Reset clears the countdown, the running flag and all stage valids.
`include "mmss_countdown_timer_unit_defines.svh"

module mmss_countdown_timer_unit #(
	parameter int unsigned TICKS_PER_SECOND = mct_pkg::TICKS_PER_SECOND_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input mct_pkg::in_item_t in_item,
	output logic out_valid,
	input logic out_stall,
	output mct_pkg::out_item_t out_item
);

	localparam int unsigned RW = $clog2(TICKS_PER_SECOND + 1);

	logic adv;
	mct_pkg::pipe_ctl_t ctl_s2;
	mct_pkg::pipe_ctl_t ctl_s5;
	logic [mct_pkg::MS_W-1:0] q_s5;
	logic [RW-1:0] r_s5;

	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv;

	mct_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.in_valid(in_valid),
		.in_item(in_item),
		.ctl_s2(ctl_s2)
	);

	mct_div #(
		.TICKS_PER_SECOND(TICKS_PER_SECOND)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.ctl_s2(ctl_s2),
		.ctl_s5(ctl_s5),
		.q_s5(q_s5),
		.r_s5(r_s5)
	);

	mct_core #(
		.TICKS_PER_SECOND(TICKS_PER_SECOND)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.ctl_s5(ctl_s5),
		.q_s5(q_s5),
		.r_s5(r_s5),
		.out_valid(out_valid),
		.out_item(out_item)
	);

	`MCT_ASSERT_NOW(a_rem_range, out_valid,
		out_item.remaining_seconds <= mct_pkg::MAX_REMAINING, "remaining time out of range")
	`MCT_ASSERT_NOW(a_load_runs, out_valid && out_item.load_accepted,
		out_item.running, "accepted load without running flag")
	`MCT_ASSERT_NEXT(a_run_sticky, out_valid && !out_stall && out_item.running,
		!out_valid || out_item.running, "running flag dropped")

endmodule

// ----- test/mmss_countdown_timer_unit_test.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the MM:SS countdown timer, with its own timer model and a scoreboard.
// Depends on mct_pkg and mmss_countdown_timer_unit. Drives directed and random loads and ticks
// under random input gaps and output stalls.

module mmss_countdown_timer_unit_test;

	localparam int unsigned MS_PER_SEC = mct_pkg::TICKS_PER_SECOND_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int RANDOM_ITEMS = 450;
	localparam int DRAIN_CYCLES = 20;

	typedef enum int {
		STALL_NONE,
		STALL_RANDOM,
		STALL_RUNS
	} stall_pattern_t;

	class countdown_scoreboard;
		logic [mct_pkg::REM_W-1:0] secs_left;
		logic [mct_pkg::MS_W-1:0] mark_ms;
		bit armed;
		mct_pkg::out_item_t pending[$];
		int mismatches;
		int results_seen;
		int loads_taken;
		int loads_refused;
		int ticks_seen;
		int zero_ticks;

		function new();
			secs_left = '0;
			mark_ms = '0;
			armed = 1'b0;
			mismatches = 0;
			results_seen = 0;
			loads_taken = 0;
			loads_refused = 0;
			ticks_seen = 0;
			zero_ticks = 0;
		endfunction

		function bit is_digit(logic [7:0] c);
			return c >= mct_pkg::CHAR_ZERO && c <= mct_pkg::CHAR_NINE;
		endfunction

		function void note_input(mct_pkg::in_item_t it);
			logic [mct_pkg::MS_W-1:0] elapsed;
			logic [mct_pkg::MS_W-1:0] whole;
			int total;
			bit ok;
			mct_pkg::out_item_t want;
			want.load_accepted = 1'b0;
			if (it.opcode == mct_pkg::OP_LOAD) begin
				ok = it.text_length == mct_pkg::TEXT_LEN && it.char_2 == mct_pkg::CHAR_COLON
					&& is_digit(it.char_0) && is_digit(it.char_1)
					&& is_digit(it.char_3) && is_digit(it.char_4)
					&& it.char_3 - mct_pkg::CHAR_ZERO < 6;
				if (ok) begin
					total = ((it.char_0 - mct_pkg::CHAR_ZERO) * 10
						+ (it.char_1 - mct_pkg::CHAR_ZERO)) * 60
						+ (it.char_3 - mct_pkg::CHAR_ZERO) * 10
						+ (it.char_4 - mct_pkg::CHAR_ZERO);
					secs_left = mct_pkg::REM_W'(total);
					mark_ms = it.now_ms;
					armed = 1'b1;
					want.load_accepted = 1'b1;
					loads_taken++;
				end else begin
					loads_refused++;
				end
			end else begin
				ticks_seen++;
				if (armed) begin
					elapsed = it.now_ms - mark_ms;
					whole = elapsed / MS_PER_SEC;
					if (whole != 0) begin
						if (whole >= mct_pkg::MS_W'(secs_left))
							secs_left = '0;
						else
							secs_left = secs_left - mct_pkg::REM_W'(whole);
						mark_ms = mark_ms + whole * MS_PER_SEC;
					end
					if (secs_left == 0)
						zero_ticks++;
				end
			end
			want.remaining_seconds = secs_left;
			want.running = armed;
			pending.push_back(want);
		endfunction

		task report(string what);
			$display("[%0t] mismatch: %s", $realtime, what);
			mismatches++;
		endtask

		task check_result(mct_pkg::out_item_t got);
			mct_pkg::out_item_t want;
			if (pending.size() == 0) begin
				report($sformatf("result %0d/%0b/%0b with no item waiting",
					got.remaining_seconds, got.running, got.load_accepted));
				return;
			end
			want = pending.pop_front();
			results_seen++;
			if (got.remaining_seconds !== want.remaining_seconds)
				report($sformatf("remaining_seconds %0d, expected %0d",
					got.remaining_seconds, want.remaining_seconds));
			if (got.running !== want.running)
				report($sformatf("running %b, expected %b", got.running, want.running));
			if (got.load_accepted !== want.load_accepted)
				report($sformatf("load_accepted %b, expected %b",
					got.load_accepted, want.load_accepted));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	mct_pkg::in_item_t in_item;
	logic out_valid;
	logic out_stall = 1'b0;
	mct_pkg::out_item_t out_item;

	countdown_scoreboard board = new();
	int accepted_total = 0;
	int sent_total = 0;
	int cycles = 0;
	int burst_left = 0;
	int gap_max = 0;
	stall_pattern_t stall_mode = STALL_NONE;
	int stall_run = 0;
	bit stall_hold = 1'b0;

	mmss_countdown_timer_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_item(out_item)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d items waiting", cycles, board.pending.size());
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				board.check_result(out_item);
			if (in_valid && !in_stall) begin
				board.note_input(in_item);
				accepted_total++;
			end
		end
	end

	always @(negedge clk) begin
		if (stall_mode == STALL_NONE) begin
			out_stall <= 1'b0;
		end else if (stall_mode == STALL_RANDOM) begin
			out_stall <= ($urandom_range(0, 2) == 0);
		end else begin
			if (stall_run == 0) begin
				stall_hold = !stall_hold;
				stall_run = stall_hold ? $urandom_range(1, 8) : $urandom_range(1, 16);
			end
			stall_run--;
			out_stall <= stall_hold;
		end
	end

	function automatic mct_pkg::in_item_t raw_load(logic [31:0] at_ms, logic [3:0] len,
		logic [7:0] c0, logic [7:0] c1, logic [7:0] c2, logic [7:0] c3, logic [7:0] c4);
		mct_pkg::in_item_t it;
		it.opcode = mct_pkg::OP_LOAD;
		it.now_ms = at_ms;
		it.text_length = len;
		it.char_0 = c0;
		it.char_1 = c1;
		it.char_2 = c2;
		it.char_3 = c3;
		it.char_4 = c4;
		return it;
	endfunction

	function automatic mct_pkg::in_item_t text_load(logic [31:0] at_ms, int mm, int ss);
		return raw_load(at_ms, mct_pkg::TEXT_LEN,
			mct_pkg::CHAR_ZERO + 8'(mm / 10), mct_pkg::CHAR_ZERO + 8'(mm % 10),
			mct_pkg::CHAR_COLON,
			mct_pkg::CHAR_ZERO + 8'(ss / 10), mct_pkg::CHAR_ZERO + 8'(ss % 10));
	endfunction

	// The text fields of a tick carry random bytes; the block must ignore them.
	function automatic mct_pkg::in_item_t tick_item(logic [31:0] at_ms);
		mct_pkg::in_item_t it;
		it = raw_load(at_ms, 4'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom), 8'($urandom));
		it.opcode = mct_pkg::OP_TICK;
		return it;
	endfunction

	// Called at a falling edge; returns at the falling edge after the item is taken.
	task automatic send_item(mct_pkg::in_item_t it);
		int gap;
		int target;
		if (burst_left == 0) begin
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		in_item <= it;
		in_valid <= 1'b1;
		target = sent_total + 1;
		do @(negedge clk); while (accepted_total < target);
		sent_total = target;
	endtask

	initial begin
		mct_pkg::in_item_t it;
		logic [31:0] wall_ms;
		logic [31:0] step;
		int phase_end;
		int mm;
		int ss;
		int n;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		gap_max = 2;
		stall_mode = STALL_RUNS;
		send_item(tick_item(32'h0000_0000));
		send_item(tick_item(32'hFFFF_FFFF));
		send_item(raw_load(32'h0000_1000, 4'd4, "1", "2", mct_pkg::CHAR_COLON, "3", "4"));
		send_item(raw_load(32'h0000_1000, 4'd15, "1", "2", mct_pkg::CHAR_COLON, "3", "4"));
		send_item(raw_load(32'h0000_1000, mct_pkg::TEXT_LEN, "1", "2", ";", "3", "4"));
		send_item(raw_load(32'h0000_1000, mct_pkg::TEXT_LEN, "/", "2", mct_pkg::CHAR_COLON,
			"3", "4"));
		send_item(raw_load(32'h0000_1000, mct_pkg::TEXT_LEN, "1", "2", mct_pkg::CHAR_COLON,
			"3", ":"));
		send_item(raw_load(32'h0000_1000, mct_pkg::TEXT_LEN, "0", "0", mct_pkg::CHAR_COLON,
			"6", "0"));
		send_item(raw_load(32'hFFFF_FFFF, 4'd0, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF));
		send_item(text_load(32'h0000_0000, 0, 0));
		send_item(tick_item(32'h0000_1388));
		send_item(text_load(32'hFFFF_FC18, 99, 59));
		send_item(tick_item(32'hFFFF_FFFF));
		send_item(tick_item(32'h0000_0000));
		send_item(tick_item(32'h0000_0BB7));
		send_item(tick_item(32'h0000_0000));
		send_item(text_load(32'h8000_0000, 1, 0));
		send_item(text_load(32'h8000_1234, 45, 7));
		send_item(tick_item(32'h8000_1234 + 32'd59_999));
		send_item(raw_load(32'h8001_0000, mct_pkg::TEXT_LEN, "9", "a", mct_pkg::CHAR_COLON,
			"0", "0"));
		send_item(tick_item(32'h8000_1234 + 32'd7_000_000));
		send_item(text_load(32'h7FFF_FFFF, 0, 59));
		send_item(tick_item(32'h7FFF_FFFF + 32'd59_999));
		send_item(tick_item(32'h5555_5555));

		wall_ms = $urandom;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					gap_max = 0;
					stall_mode = STALL_NONE;
				end
				1: begin
					gap_max = 6;
					stall_mode = STALL_RANDOM;
				end
				2: begin
					gap_max = 3;
					stall_mode = STALL_RUNS;
				end
				default: begin
					gap_max = 10;
					stall_mode = STALL_RANDOM;
				end
			endcase
			phase_end = sent_total + RANDOM_ITEMS / 4;
			while (sent_total < phase_end) begin
				case ($urandom_range(0, 9))
					7: begin
						it = text_load(wall_ms, $urandom_range(0, 99), $urandom_range(0, 59));
						case ($urandom_range(0, 6))
							0: it.text_length = 4'($urandom);
							1: it.char_2 = 8'($urandom);
							2: it.char_0 = 8'($urandom);
							3: it.char_1 = 8'($urandom);
							4: it.char_4 = 8'($urandom);
							5: it.char_3 = 8'($urandom);
							default: it.char_3 = mct_pkg::CHAR_ZERO + 8'($urandom_range(6, 9));
						endcase
						send_item(it);
					end
					8: begin
						send_item(raw_load($urandom, 4'($urandom), 8'($urandom), 8'($urandom),
							8'($urandom), 8'($urandom), 8'($urandom)));
					end
					9: begin
						send_item(tick_item($urandom));
					end
					default: begin
						if ($urandom_range(0, 7) == 0)
							wall_ms = $urandom;
						mm = $urandom_range(0, 1) ? 0 : $urandom_range(0, 99);
						ss = $urandom_range(0, 59);
						send_item(text_load(wall_ms, mm, ss));
						n = $urandom_range(1, 10);
						repeat (n) begin
							case ($urandom_range(0, 9))
								0: step = $urandom;
								1, 2: step = $urandom_range(0, 120000);
								default: step = $urandom_range(0, 2500);
							endcase
							wall_ms = wall_ms + step;
							send_item(tick_item(wall_ms));
						end
					end
				endcase
			end
		end
		in_valid <= 1'b0;

		while (board.pending.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Ran %0d items: %0d loads taken, %0d loads refused, %0d ticks.",
			sent_total, board.loads_taken, board.loads_refused, board.ticks_seen);
		$display("%0d results checked; %0d ticks left the countdown at zero.",
			board.results_seen, board.zero_ticks);
		if (board.mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/mct_pkg.sv
rtl/mct_front.sv
rtl/mct_div.sv
rtl/mct_core.sv
rtl/mmss_countdown_timer_unit.sv
test/mmss_countdown_timer_unit_test.sv
